>>> rtl/core/bibs_pkg.sv
// ----------------------------------------------------------------------------
// bibs_pkg
// Shared constants and types for the boot image block sender.
// ----------------------------------------------------------------------------
package bibs_pkg;

	localparam int HEADER_BYTES       = 22;
	localparam int FLASH_BUFFER_BYTES = 2048;
	localparam int FB_BITS            = $clog2(FLASH_BUFFER_BYTES);
	localparam int COUNT_W            = 18;
	localparam int QUEUE_DEPTH        = 2;

	localparam logic [2:0] PH_HEADER = 3'd0;
	localparam logic [2:0] PH_DATA   = 3'd1;
	localparam logic [2:0] PH_WAIT   = 3'd2;
	localparam logic [2:0] PH_DONE   = 3'd3;
	localparam logic [2:0] PH_ERROR  = 3'd4;

	localparam logic [2:0] ST_ACCEPT   = 3'd0;
	localparam logic [2:0] ST_AWAIT    = 3'd1;
	localparam logic [2:0] ST_OK       = 3'd2;
	localparam logic [2:0] ST_MISMATCH = 3'd3;
	localparam logic [2:0] ST_COMPLETE = 3'd4;
	localparam logic [2:0] ST_REJECT   = 3'd5;

	typedef struct packed {
		logic       is_cksum;
		logic [7:0] data_byte;
	} item_t;

	typedef struct packed {
		logic        valid;
		item_t       item;
	} queue_out_t;

	typedef struct packed {
		logic [15:0] running_checksum;
		logic        tx_valid;
		logic [7:0]  tx_byte;
		logic [2:0]  status;
	} result_t;

	localparam int RESULT_W = $bits(result_t);
	localparam int TDATA_W  = ((RESULT_W + 7) / 8) * 8;

endpackage

>>> rtl/core/bibs_front.sv
// ----------------------------------------------------------------------------
// bibs_front
// Accepts input beats, tags each one as an image byte or a returned checksum
// byte, and holds them in a two-entry queue for the back end.
// ----------------------------------------------------------------------------
module bibs_front (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    s_tvalid,
	output logic                    s_tready,
	input  logic [7:0]              s_tdata,   // [7:0] data_byte
	input  logic                    s_tuser,   // [0] opcode
	output bibs_pkg::queue_out_t    q_out,
	input  logic                    q_pop
);

	bibs_pkg::item_t entry_q [bibs_pkg::QUEUE_DEPTH];
	logic            wr_ptr_q;
	logic            rd_ptr_q;
	logic [1:0]      count_q;
	logic            push;
	logic            pop;
	bibs_pkg::item_t new_item;

	assign s_tready = (count_q != 2'(bibs_pkg::QUEUE_DEPTH));
	assign push     = s_tvalid && s_tready;
	assign pop      = q_pop && (count_q != 2'd0);

	assign new_item.is_cksum  = s_tuser;
	assign new_item.data_byte = s_tdata;

	assign q_out.valid = (count_q != 2'd0);
	assign q_out.item  = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= new_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= 2'(bibs_pkg::QUEUE_DEPTH))
		else $error("queue count beyond depth");

	assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> (count_q != 2'd0))
		else $error("queue empty after push");

	assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == 2'd0) |-> (wr_ptr_q == rd_ptr_q))
		else $error("queue pointers disagree while empty");

endmodule

>>> rtl/core/bibs_back.sv
// ----------------------------------------------------------------------------
// bibs_back
// Runs the transfer state machine on one queued item per cycle while the result
// beat is not stalled: checksum accumulation, header and block counting,
// checksum exchange, and the registered result beat.
// ----------------------------------------------------------------------------
module bibs_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  bibs_pkg::queue_out_t q_in,
	output logic                 q_pop,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output bibs_pkg::result_t    m_result
);

	logic [2:0]                     phase_q;
	logic [15:0]                    sum_q;
	logic [bibs_pkg::COUNT_W-1:0]   count_q;
	logic [15:0]                    words_q;
	logic [7:0]                     rx_low_q;
	logic                           low_seen_q;
	logic                           clear_after_q;
	logic                           out_valid_q;
	bibs_pkg::result_t              out_q;

	logic [2:0]                     phase_d;
	logic [15:0]                    sum_d;
	logic [bibs_pkg::COUNT_W-1:0]   count_d;
	logic [15:0]                    words_d;
	logic [7:0]                     rx_low_d;
	logic                           low_seen_d;
	logic                           clear_after_d;
	bibs_pkg::result_t              res;

	logic                           take;
	logic                           is_ck;
	logic [7:0]                     b;
	logic [15:0]                    sum_add;
	logic [bibs_pkg::COUNT_W-1:0]   count_inc;
	logic [bibs_pkg::COUNT_W-1:0]   block_len;
	logic [bibs_pkg::COUNT_W-1:0]   past_head;

	assign take  = q_in.valid && (!out_valid_q || m_tready);
	assign q_pop = take;
	assign is_ck = q_in.item.is_cksum;
	assign b     = q_in.item.data_byte;

	assign sum_add   = sum_q + {8'd0, b};
	assign count_inc = count_q + bibs_pkg::COUNT_W'(1);
	assign past_head = count_inc - bibs_pkg::COUNT_W'(6);

	always_comb begin
		phase_d       = phase_q;
		sum_d         = sum_q;
		count_d       = count_q;
		words_d       = words_q;
		rx_low_d      = rx_low_q;
		low_seen_d    = low_seen_q;
		clear_after_d = clear_after_q;
		res.status    = bibs_pkg::ST_ACCEPT;
		res.tx_byte   = 8'd0;
		res.tx_valid  = 1'b0;
		block_len     = '0;
		case (phase_q)
			bibs_pkg::PH_DONE: begin
				res.status = bibs_pkg::ST_COMPLETE;
			end
			bibs_pkg::PH_ERROR: begin
				res.status = bibs_pkg::ST_MISMATCH;
			end
			bibs_pkg::PH_WAIT: begin
				if (!is_ck) begin
					res.status = bibs_pkg::ST_REJECT;
				end else if (!low_seen_q) begin
					rx_low_d   = b;
					low_seen_d = 1'b1;
					res.status = bibs_pkg::ST_AWAIT;
				end else begin
					low_seen_d = 1'b0;
					if ({b, rx_low_q} != sum_q) begin
						phase_d    = bibs_pkg::PH_ERROR;
						res.status = bibs_pkg::ST_MISMATCH;
					end else begin
						sum_d = 16'd0;
						if (clear_after_q) begin
							count_d = '0;
							words_d = 16'd0;
						end
						clear_after_d = 1'b0;
						phase_d       = bibs_pkg::PH_DATA;
						res.status    = bibs_pkg::ST_OK;
					end
				end
			end
			bibs_pkg::PH_HEADER: begin
				if (is_ck) begin
					res.status = bibs_pkg::ST_REJECT;
				end else begin
					sum_d        = sum_add;
					count_d      = count_inc;
					res.tx_byte  = b;
					res.tx_valid = 1'b1;
					if (count_inc >= bibs_pkg::COUNT_W'(bibs_pkg::HEADER_BYTES)) begin
						phase_d       = bibs_pkg::PH_WAIT;
						low_seen_d    = 1'b0;
						rx_low_d      = 8'd0;
						clear_after_d = 1'b1;
						res.status    = bibs_pkg::ST_AWAIT;
					end
				end
			end
			bibs_pkg::PH_DATA: begin
				if (is_ck) begin
					res.status = bibs_pkg::ST_REJECT;
				end else begin
					sum_d        = sum_add;
					count_d      = count_inc;
					res.tx_byte  = b;
					res.tx_valid = 1'b1;
					if (count_q == '0) begin
						words_d = {8'd0, b};
					end else if (count_q == bibs_pkg::COUNT_W'(1)) begin
						words_d = {b, words_q[7:0]};
					end
					block_len = bibs_pkg::COUNT_W'({words_d, 1'b0})
						+ bibs_pkg::COUNT_W'(6);
					if ((words_d == 16'd0) && (count_inc > bibs_pkg::COUNT_W'(1))) begin
						phase_d    = bibs_pkg::PH_DONE;
						res.status = bibs_pkg::ST_COMPLETE;
					end else if (count_inc == block_len) begin
						phase_d       = bibs_pkg::PH_WAIT;
						low_seen_d    = 1'b0;
						rx_low_d      = 8'd0;
						clear_after_d = 1'b1;
						res.status    = bibs_pkg::ST_AWAIT;
					end else if ((count_inc > bibs_pkg::COUNT_W'(6))
						&& (past_head[bibs_pkg::FB_BITS-1:0] == '0)) begin
						phase_d       = bibs_pkg::PH_WAIT;
						low_seen_d    = 1'b0;
						rx_low_d      = 8'd0;
						clear_after_d = 1'b0;
						res.status    = bibs_pkg::ST_AWAIT;
					end
				end
			end
			default: begin
				phase_d = bibs_pkg::PH_ERROR;
			end
		endcase
		res.running_checksum = sum_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= bibs_pkg::PH_HEADER;
			sum_q         <= 16'd0;
			count_q       <= '0;
			words_q       <= 16'd0;
			rx_low_q      <= 8'd0;
			low_seen_q    <= 1'b0;
			clear_after_q <= 1'b0;
			out_valid_q   <= 1'b0;
		end else begin
			if (take) begin
				phase_q       <= phase_d;
				sum_q         <= sum_d;
				count_q       <= count_d;
				words_q       <= words_d;
				rx_low_q      <= rx_low_d;
				low_seen_q    <= low_seen_d;
				clear_after_q <= clear_after_d;
				out_valid_q   <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			out_q <= res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_result = out_q;

	assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == bibs_pkg::PH_DONE) |=> (phase_q == bibs_pkg::PH_DONE))
		else $error("image complete state left");

	assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == bibs_pkg::PH_ERROR) |=> (phase_q == bibs_pkg::PH_ERROR))
		else $error("sticky error cleared");

	assert property (@(posedge clk) disable iff (!arst_n)
		low_seen_q |-> (phase_q == bibs_pkg::PH_WAIT))
		else $error("low checksum byte held outside a checksum wait");

	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.tx_valid) |-> ((out_q.status == bibs_pkg::ST_ACCEPT)
			|| (out_q.status == bibs_pkg::ST_AWAIT)
			|| (out_q.status == bibs_pkg::ST_COMPLETE)))
		else $error("byte sent with a status that forbids it");

	assert property (@(posedge clk) disable iff (!arst_n)
		(take && (phase_q == bibs_pkg::PH_WAIT) && low_seen_q && is_ck
			&& ({b, rx_low_q} == sum_q)) |=> (sum_q == 16'd0))
		else $error("sum not cleared after a matching checksum");

endmodule

>>> rtl/core/boot_image_block_sender.sv
// ----------------------------------------------------------------------------
// boot_image_block_sender
// Host side of a boot-loader image transfer with block checksum exchange.
// An accepted input beat is held in the queue and then registered as its result beat.
// Throughput is one beat per cycle while result back-pressure does not stall the state update.
// A two-entry queue separates input acceptance from result back-pressure.
// The asynchronous reset returns the block to the header phase, empty.
// ----------------------------------------------------------------------------
module boot_image_block_sender (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [7:0]                    s_tdata,   // [7:0] data_byte
	input  logic                          s_tuser,   // [0] opcode
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// [2:0] status, [10:3] tx_byte, [11] tx_valid, [27:12] running_checksum
	output logic [bibs_pkg::TDATA_W-1:0]  m_tdata
);

	bibs_pkg::queue_out_t q_out;
	logic                 q_pop;
	bibs_pkg::result_t    result;

	bibs_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.q_out    (q_out),
		.q_pop    (q_pop)
	);

	bibs_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_in     (q_out),
		.q_pop    (q_pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_result (result)
	);

	assign m_tdata = bibs_pkg::TDATA_W'(result);

endmodule

>>> dv/boot_image_block_sender_test.sv
// ----------------------------------------------------------------------------
// boot_image_block_sender_test
// Streams a whole boot image into the block sender, with header and block
// checksum exchanges, wrong-opcode noise and a sticky ending. Each result
// beat is checked against an in-bench model of the sender, with random idle
// gaps on both sides.
// ----------------------------------------------------------------------------
module boot_image_block_sender_test;
	timeunit 1ns;
	timeprecision 1ps;

	import bibs_pkg::*;

	typedef enum logic {OP_IMAGE = 1'b0, OP_CKSUM = 1'b1} opcode_e;
	typedef enum int {SRC_LIT, SRC_SUM_LO, SRC_SUM_HI} byte_src_e;

	typedef struct {
		opcode_e    op;
		logic [7:0] data;
		byte_src_e  src;
		int         typed;
	} header_row_t;

	localparam int NO_TYPED      = -1;
	localparam int RANDOM_ITEMS  = 480;
	localparam int LONG_HOLD     = 150;
	localparam int STALL_LIMIT   = 1000;
	localparam int TAIL_CYCLES   = 16;

	logic                clk;
	logic                arst_n;
	logic                s_tvalid;
	logic                s_tready;
	logic [7:0]          s_tdata;
	logic                s_tuser;
	logic                m_tvalid;
	logic                m_tready;
	logic [TDATA_W-1:0]  m_tdata;

	int      beat_typed;
	bit      quiet;
	bit      hold_req;
	int      fail_count;
	int      stall_cycles;
	int      sent_items;
	result_t tx_reports_due[$];

	logic [2:0]  snd_phase;
	logic [15:0] img_sum;
	logic [17:0] blk_count;
	logic [15:0] blk_words;
	logic [7:0]  cksum_lo;
	logic        lo_held;
	logic        clear_on_ok;

	header_row_t header_rows[26] = '{
		'{OP_IMAGE, 8'h00, SRC_LIT, ST_ACCEPT},
		'{OP_CKSUM, 8'h5A, SRC_LIT, ST_REJECT},
		'{OP_IMAGE, 8'hFF, SRC_LIT, ST_ACCEPT},
		'{OP_IMAGE, 8'h80, SRC_LIT, NO_TYPED},
		'{OP_IMAGE, 8'h7F, SRC_LIT, NO_TYPED},
		'{OP_IMAGE, 8'h01, SRC_LIT, NO_TYPED},
		'{OP_IMAGE, 8'hFE, SRC_LIT, NO_TYPED},
		'{OP_IMAGE, 8'h55, SRC_LIT, NO_TYPED},
		'{OP_IMAGE, 8'hAA, SRC_LIT, NO_TYPED},
		'{OP_IMAGE, 8'h33, SRC_LIT, NO_TYPED},
		'{OP_IMAGE, 8'hCC, SRC_LIT, NO_TYPED},
		'{OP_IMAGE, 8'h0F, SRC_LIT, NO_TYPED},
		'{OP_IMAGE, 8'hF0, SRC_LIT, NO_TYPED},
		'{OP_IMAGE, 8'h12, SRC_LIT, NO_TYPED},
		'{OP_IMAGE, 8'h34, SRC_LIT, NO_TYPED},
		'{OP_IMAGE, 8'h56, SRC_LIT, NO_TYPED},
		'{OP_IMAGE, 8'h78, SRC_LIT, NO_TYPED},
		'{OP_IMAGE, 8'h9A, SRC_LIT, NO_TYPED},
		'{OP_IMAGE, 8'hBC, SRC_LIT, NO_TYPED},
		'{OP_IMAGE, 8'hDE, SRC_LIT, NO_TYPED},
		'{OP_IMAGE, 8'hC3, SRC_LIT, NO_TYPED},
		'{OP_IMAGE, 8'h3C, SRC_LIT, NO_TYPED},
		'{OP_IMAGE, 8'h99, SRC_LIT, ST_AWAIT},
		'{OP_IMAGE, 8'h44, SRC_LIT, ST_REJECT},
		'{OP_CKSUM, 8'h00, SRC_SUM_LO, ST_AWAIT},
		'{OP_CKSUM, 8'h00, SRC_SUM_HI, ST_OK}
	};

	boot_image_block_sender dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic void enter_wait(input logic clear_after);
		snd_phase   = PH_WAIT;
		lo_held     = 1'b0;
		cksum_lo    = 8'h00;
		clear_on_ok = clear_after;
	endfunction

	function automatic result_t advance_sender(input logic op, input logic [7:0] b);
		result_t r;
		r = '0;
		r.status = ST_ACCEPT;
		case (snd_phase)
			PH_DONE: r.status = ST_COMPLETE;
			PH_ERROR: r.status = ST_MISMATCH;
			PH_WAIT: begin
				if (op != OP_CKSUM) begin
					r.status = ST_REJECT;
				end else if (!lo_held) begin
					cksum_lo = b;
					lo_held  = 1'b1;
					r.status = ST_AWAIT;
				end else begin
					lo_held = 1'b0;
					if ({b, cksum_lo} != img_sum) begin
						snd_phase = PH_ERROR;
						r.status  = ST_MISMATCH;
					end else begin
						img_sum = '0;
						if (clear_on_ok) begin
							blk_count = '0;
							blk_words = '0;
						end
						clear_on_ok = 1'b0;
						snd_phase   = PH_DATA;
						r.status    = ST_OK;
					end
				end
			end
			default: begin
				if (op != OP_IMAGE) begin
					r.status = ST_REJECT;
				end else begin
					img_sum    = img_sum + 16'(b);
					r.tx_byte  = b;
					r.tx_valid = 1'b1;
					if (snd_phase == PH_HEADER) begin
						blk_count = blk_count + 1'b1;
						if (int'(blk_count) >= HEADER_BYTES) begin
							enter_wait(1'b1);
							r.status = ST_AWAIT;
						end
					end else begin
						if (blk_count == 0)
							blk_words = {8'h00, b};
						else if (blk_count == 1)
							blk_words[15:8] = b;
						blk_count = blk_count + 1'b1;
						if (blk_words == 0 && blk_count > 1) begin
							snd_phase = PH_DONE;
							r.status  = ST_COMPLETE;
						end else if (int'(blk_count) == 2 * (int'(blk_words) + 3)) begin
							enter_wait(1'b1);
							r.status = ST_AWAIT;
						end else if (blk_count > 6 &&
								(int'(blk_count) - 6) % FLASH_BUFFER_BYTES == 0) begin
							enter_wait(1'b0);
							r.status = ST_AWAIT;
						end
					end
				end
			end
		endcase
		r.running_checksum = img_sum;
		return r;
	endfunction

	function automatic int pick_gap();
		int roll;
		if (quiet)
			return 0;
		roll = $urandom_range(0, 99);
		if (roll < 55)
			return 0;
		if (roll < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	always @(posedge clk) begin : check_beats
		result_t want;
		result_t got;
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				want = advance_sender(s_tuser, s_tdata);
				if (beat_typed != NO_TYPED)
					want.status = beat_typed[2:0];
				tx_reports_due.push_back(want);
			end
			if (m_tvalid && m_tready) begin
				got = result_t'(m_tdata[RESULT_W-1:0]);
				if (tx_reports_due.size() == 0) begin
					$error("result beat with no expectation waiting: %h", m_tdata);
					fail_count++;
				end else begin
					want = tx_reports_due.pop_front();
					if (got.status !== want.status) begin
						$error("status: expected %0d, got %0d", want.status, got.status);
						fail_count++;
					end
					if (got.tx_byte !== want.tx_byte) begin
						$error("tx_byte: expected %h, got %h", want.tx_byte, got.tx_byte);
						fail_count++;
					end
					if (got.tx_valid !== want.tx_valid) begin
						$error("tx_valid: expected %b, got %b", want.tx_valid, got.tx_valid);
						fail_count++;
					end
					if (got.running_checksum !== want.running_checksum) begin
						$error("running_checksum: expected %h, got %h",
							want.running_checksum, got.running_checksum);
						fail_count++;
					end
				end
			end
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				stall_cycles = 0;
			else
				stall_cycles++;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("boot_image_block_sender regression: fail");
				$finish;
			end
		end
	end

	initial begin : sink
		int stall_left;
		stall_left = 0;
		m_tready   = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				m_tready <= 1'b0;
				repeat (LONG_HOLD) @(negedge clk);
				m_tready <= 1'b1;
			end else if (stall_left > 0) begin
				m_tready <= 1'b0;
				stall_left--;
			end else begin
				m_tready <= 1'b1;
				stall_left = pick_gap();
			end
		end
	end

	task automatic send_beat(input logic op, input logic [7:0] b, input int typed);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid   <= 1'b1;
		s_tuser    <= op;
		s_tdata    <= b;
		beat_typed <= typed;
		do @(posedge clk); while (!s_tready);
		sent_items++;
		@(negedge clk);
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (tx_reports_due.size() != 0) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic return_checksum(input logic [15:0] skew);
		logic [15:0] reply;
		reply = img_sum ^ skew;
		if ($urandom_range(0, 5) == 0)
			send_beat(OP_IMAGE, 8'($urandom_range(0, 255)), NO_TYPED);
		send_beat(OP_CKSUM, reply[7:0], NO_TYPED);
		if ($urandom_range(0, 7) == 0)
			send_beat(OP_IMAGE, 8'($urandom_range(0, 255)), NO_TYPED);
		send_beat(OP_CKSUM, reply[15:8], NO_TYPED);
	endtask

	task automatic send_block(input int words, input logic [15:0] skew);
		int         span;
		logic [7:0] b;
		span = 2 * (words + 3);
		for (int i = 0; i < span; i++) begin
			if ($urandom_range(0, 15) == 0)
				send_beat(OP_CKSUM, 8'($urandom_range(0, 255)), NO_TYPED);
			if (i == 0)
				b = words[7:0];
			else if (i == 1)
				b = words[15:8];
			else
				b = 8'($urandom_range(0, 255));
			send_beat(OP_IMAGE, b, NO_TYPED);
			if (snd_phase == PH_WAIT)
				return_checksum(skew);
		end
	endtask

	initial begin : stimulus
		logic [7:0] b;
		int         words;
		int         blk;
		int         tail_status;
		arst_n       = 1'b0;
		s_tvalid     = 1'b0;
		s_tuser      = 1'b0;
		s_tdata      = 8'h00;
		beat_typed   = NO_TYPED;
		quiet        = 1'b0;
		hold_req     = 1'b0;
		fail_count   = 0;
		stall_cycles = 0;
		sent_items   = 0;
		snd_phase    = PH_HEADER;
		img_sum      = '0;
		blk_count    = '0;
		blk_words    = '0;
		cksum_lo     = '0;
		lo_held      = 1'b0;
		clear_on_ok  = 1'b0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (header_rows[i]) begin
			case (header_rows[i].src)
				SRC_SUM_LO: b = img_sum[7:0];
				SRC_SUM_HI: b = img_sum[15:8];
				default: b = header_rows[i].data;
			endcase
			send_beat(header_rows[i].op, b, header_rows[i].typed);
		end

		sent_items = 0;
		blk        = 0;
		while (sent_items < RANDOM_ITEMS) begin
			quiet = (blk % 5 == 4);
			if (blk == 3)
				hold_req = 1'b1;
			if (blk == 6)
				wait_drained();
			words = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 40)
				: $urandom_range(1, 12);
			send_block(words, 16'h0000);
			blk++;
		end

		quiet = 1'b0;
		if ($urandom_range(0, 1) == 1) begin
			send_beat(OP_IMAGE, 8'h00, NO_TYPED);
			send_beat(OP_IMAGE, 8'h00, ST_COMPLETE);
			tail_status = ST_COMPLETE;
		end else begin
			send_block($urandom_range(1, 6), 16'($urandom_range(1, 65535)));
			tail_status = ST_MISMATCH;
		end
		repeat (8)
			send_beat(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)), tail_status);

		wait_drained();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (fail_count == 0 && tx_reports_due.size() == 0)
			$display("boot_image_block_sender regression: pass");
		else
			$display("boot_image_block_sender regression: fail");
		$finish;
	end

endmodule
